// File: hw/rtl/cst_pkg.sv
package cst_pkg;

  localparam int LengthBitsDefault = 16;
  localparam int LineBitsDefault   = 24;
  localparam int ColumnBitsDefault = 16;

  localparam int KindBits  = 7;
  localparam int ValueBits = 32;
  localparam int NumKw     = 19;

  // token kinds
  localparam logic [6:0] K_END     = 7'd0;
  localparam logic [6:0] K_IDENT   = 7'd1;
  localparam logic [6:0] K_NUMBER  = 7'd2;
  localparam logic [6:0] K_STRING  = 7'd3;
  localparam logic [6:0] K_CHAR    = 7'd4;
  localparam logic [6:0] K_KEYWORD = 7'd5;
  localparam logic [6:0] K_PAIR    = 7'd24;
  localparam logic [6:0] K_SINGLE  = 7'd40;
  localparam logic [6:0] K_INVALID = 7'd65;

  // one token as it travels from the scanner to the output side
  typedef struct packed {
    logic [6:0]  kind;
    logic [31:0] value;
    logic [31:0] length;
    logic [31:0] line;
    logic [31:0] column;
    logic        last;
  } token_t;

  // keyword byte at a position, zero past its end
  function automatic logic [7:0] kw_byte(input logic [4:0] k, input logic [2:0] p);
    logic [63:0] s;
    s = 64'h0;
    unique case (k)
      5'd0:  s = {"int",      40'h0};
      5'd1:  s = {"char",     32'h0};
      5'd2:  s = {"void",     32'h0};
      5'd3:  s = {"return",   16'h0};
      5'd4:  s = {"if",       48'h0};
      5'd5:  s = {"else",     32'h0};
      5'd6:  s = {"while",    24'h0};
      5'd7:  s = {"for",      40'h0};
      5'd8:  s = {"do",       48'h0};
      5'd9:  s = {"break",    24'h0};
      5'd10: s = "continue";
      5'd11: s = {"extern",   16'h0};
      5'd12: s = {"static",   16'h0};
      5'd13: s = {"const",    24'h0};
      5'd14: s = {"sizeof",   16'h0};
      5'd15: s = {"typedef",  8'h0};
      5'd16: s = {"struct",   16'h0};
      5'd17: s = {"union",    24'h0};
      5'd18: s = {"enum",     32'h0};
      default: s = 64'h0;
    endcase
    return s[8'd63 - {p, 3'd0} -: 8];
  endfunction

  function automatic logic [3:0] kw_len(input logic [4:0] k);
    logic [3:0] r;
    unique case (k)
      5'd0, 5'd7: r = 4'd3;
      5'd1, 5'd2, 5'd5, 5'd18: r = 4'd4;
      5'd3, 5'd11, 5'd12, 5'd14, 5'd16: r = 4'd6;
      5'd4, 5'd8: r = 4'd2;
      5'd6, 5'd9, 5'd13, 5'd17: r = 4'd5;
      5'd10: r = 4'd8;
      5'd15: r = 4'd7;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  localparam logic [199:0] SingleText = "+-*/%=<>&|^~!.(){}[];,:?#";
  localparam logic [255:0] PairText   = "++--+=-=*=/=%===!=<=>=&&||<<>>->";

  function automatic logic [6:0] single_kind(input logic [7:0] c);
    logic [6:0] r;
    r = K_INVALID;
    for (int i = 24; i >= 0; i--) begin
      if (SingleText[8*(24-i) +: 8] == c) r = K_SINGLE + 7'(i);
    end
    return r;
  endfunction

  // zero when no pair matches
  function automatic logic [6:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
    logic [6:0] r;
    r = 7'd0;
    for (int i = 15; i >= 0; i--) begin
      if (PairText[16*(15-i)+8 +: 8] == a && PairText[16*(15-i) +: 8] == b)
        r = K_PAIR + 7'(i);
    end
    return r;
  endfunction

  function automatic logic starts_pair(input logic [7:0] c);
    logic r;
    r = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (PairText[16*i+8 +: 8] == c) r = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    if (c >= "0" && c <= "9") r = 5'(c - "0");
    else if (c >= "a" && c <= "f") r = 5'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") r = 5'(c - "A" + 8'd10);
    else r = 5'd16;
    return r;
  endfunction

endpackage

// File: hw/rtl/cst_scan.sv
// front part: takes one byte a beat, emits up to two tokens a beat
module cst_scan #(
  parameter int LengthBits = cst_pkg::LengthBitsDefault,
  parameter int LineBits   = cst_pkg::LineBitsDefault,
  parameter int ColumnBits = cst_pkg::ColumnBitsDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      ch,
  input  logic            eos,
  output logic [1:0]      n_tok,
  output cst_pkg::token_t tok0,
  output cst_pkg::token_t tok1
);

  typedef enum logic [3:0] {
    M_IDLE, M_LINE, M_BLOCK, M_BLOCK_STAR, M_OP, M_IDENT, M_ZERO, M_DEC, M_HEX,
    M_BIN, M_STR, M_STR_ESC, M_CH_OPEN, M_CH_ESC, M_CH_HEX, M_CH_CLOSE
  } mode_t;

  localparam logic [LengthBits-1:0] LenMax = '1;
  localparam logic [LineBits-1:0]   LineMax = '1;
  localparam logic [ColumnBits-1:0] ColMax = '1;

  mode_t                 mode, mode_next;
  logic [7:0]            held, held_next;
  logic [31:0]           acc, acc_next;
  logic [18:0]           cand, cand_next;
  logic [LengthBits-1:0] tlen, tlen_next;
  logic [LineBits-1:0]   tline, tline_next, cline;
  logic [ColumnBits-1:0] tcol, tcol_next, ccol;
  logic [1:0]            esc, esc_next;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction
  function automatic logic is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // per-byte keyword narrowing
  function automatic logic [18:0] narrow(input logic [18:0] cd, input logic [LengthBits-1:0] pos,
                                         input logic [7:0] c);
    logic [18:0] r;
    r = cd;
    for (int k = 0; k < cst_pkg::NumKw; k++) begin
      if (!(pos < LengthBits'(cst_pkg::kw_len(5'(k))) &&
            cst_pkg::kw_byte(5'(k), pos[2:0]) == c))
        r[k] = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [6:0] ident_kind(input logic [18:0] cd, input logic [LengthBits-1:0] l);
    logic [6:0] r;
    r = cst_pkg::K_IDENT;
    for (int k = cst_pkg::NumKw - 1; k >= 0; k--) begin
      if (cd[k] && LengthBits'(cst_pkg::kw_len(5'(k))) == l) r = cst_pkg::K_KEYWORD + 7'(k);
    end
    return r;
  endfunction

  logic [LengthBits-1:0] tlen_inc;
  assign tlen_inc = (tlen == LenMax) ? tlen : tlen + 1'b1;

  logic [4:0]  hv;
  logic [7:0]  c;
  logic        flush;
  logic [1:0]  n;
  cst_pkg::token_t t0, t1;
  logic        restart;
  logic [6:0]  emit_kind;
  logic [31:0] emit_val;
  logic        emit_now;

  assign c     = ch;
  assign hv    = cst_pkg::hex_val(c);
  assign flush = eos || c == 8'd0;

  function automatic cst_pkg::token_t mk(input logic [6:0] k, input logic [31:0] v,
                                         input logic [LengthBits-1:0] l,
                                         input logic [LineBits-1:0] ln,
                                         input logic [ColumnBits-1:0] cl);
    cst_pkg::token_t t;
    t.kind = k; t.value = v; t.length = 32'(l); t.line = 32'(ln); t.column = 32'(cl);
    t.last = 1'b0;
    return t;
  endfunction

  // main byte step
  always_comb begin
    mode_next = mode; held_next = held; acc_next = acc; cand_next = cand;
    tlen_next = tlen; tline_next = tline; tcol_next = tcol; esc_next = esc;
    n = 2'd0; t0 = '0; t1 = '0;
    restart = 1'b0; emit_now = 1'b0; emit_kind = '0; emit_val = '0;
    if (flush) begin
      emit_now = 1'b1;
      unique case (mode)
        M_OP:    emit_kind = cst_pkg::single_kind(held);
        M_IDENT: emit_kind = ident_kind(cand, tlen);
        M_ZERO, M_DEC, M_HEX, M_BIN: begin
          emit_kind = cst_pkg::K_NUMBER; emit_val = acc;
        end
        M_STR, M_STR_ESC: emit_kind = cst_pkg::K_STRING;
        M_CH_OPEN, M_CH_ESC, M_CH_HEX, M_CH_CLOSE: begin
          emit_kind = cst_pkg::K_CHAR; emit_val = acc;
        end
        default: emit_now = 1'b0;
      endcase
    end else begin
      unique case (mode)
        M_LINE: if (c == 8'h0a) mode_next = M_IDLE;
        M_BLOCK: if (c == "*") mode_next = M_BLOCK_STAR;
        M_BLOCK_STAR: begin
          if (c == "/") mode_next = M_IDLE;
          else if (c != "*") mode_next = M_BLOCK;
        end
        M_OP: begin
          if (held == "/" && c == "/") mode_next = M_LINE;
          else if (held == "/" && c == "*") mode_next = M_BLOCK;
          else if (cst_pkg::pair_kind(held, c) != 7'd0) begin
            emit_now = 1'b1; emit_kind = cst_pkg::pair_kind(held, c);
            tlen_next = tlen_inc; mode_next = M_IDLE;
          end else begin
            emit_now = 1'b1; emit_kind = cst_pkg::single_kind(held); restart = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(c) || is_num(c)) begin
            cand_next = narrow(cand, tlen, c); tlen_next = tlen_inc;
          end else begin
            emit_now = 1'b1; emit_kind = ident_kind(cand, tlen); restart = 1'b1;
          end
        end
        M_ZERO: begin
          if (c == "x" || c == "X") begin mode_next = M_HEX; tlen_next = tlen_inc; end
          else if (c == "b" || c == "B") begin mode_next = M_BIN; tlen_next = tlen_inc; end
          else if (is_num(c)) begin
            mode_next = M_DEC; acc_next = 32'(c - "0"); tlen_next = tlen_inc;
          end else begin
            emit_now = 1'b1; emit_kind = cst_pkg::K_NUMBER; emit_val = acc; restart = 1'b1;
          end
        end
        M_DEC: begin
          if (is_num(c)) begin
            acc_next = (acc << 3) + (acc << 1) + 32'(c - "0"); tlen_next = tlen_inc;
          end else begin
            emit_now = 1'b1; emit_kind = cst_pkg::K_NUMBER; emit_val = acc; restart = 1'b1;
          end
        end
        M_HEX: begin
          if (!hv[4]) begin
            acc_next = {acc[27:0], hv[3:0]}; tlen_next = tlen_inc;
          end else begin
            emit_now = 1'b1; emit_kind = cst_pkg::K_NUMBER; emit_val = acc; restart = 1'b1;
          end
        end
        M_BIN: begin
          if (c == "0" || c == "1") begin
            acc_next = {acc[30:0], c[0]}; tlen_next = tlen_inc;
          end else begin
            emit_now = 1'b1; emit_kind = cst_pkg::K_NUMBER; emit_val = acc; restart = 1'b1;
          end
        end
        M_STR: begin
          tlen_next = tlen_inc;
          if (c == "\"") begin
            emit_now = 1'b1; emit_kind = cst_pkg::K_STRING; mode_next = M_IDLE;
            t0 = mk(cst_pkg::K_STRING, 32'd0, tlen_inc, tline, tcol);
          end else if (c == "\\") mode_next = M_STR_ESC;
        end
        M_STR_ESC: begin tlen_next = tlen_inc; mode_next = M_STR; end
        M_CH_OPEN: begin
          tlen_next = tlen_inc;
          if (c == "\\") mode_next = M_CH_ESC;
          else begin acc_next = 32'(c); mode_next = M_CH_CLOSE; end
        end
        M_CH_ESC: begin
          tlen_next = tlen_inc; mode_next = M_CH_CLOSE;
          if (c == "n") acc_next = 32'd10;
          else if (c == "t") acc_next = 32'd9;
          else if (c == "r") acc_next = 32'd13;
          else if (c == "0") acc_next = 32'd0;
          else if (c == "x") begin acc_next = '0; esc_next = '0; mode_next = M_CH_HEX; end
          else acc_next = 32'(c);
        end
        M_CH_HEX, M_CH_CLOSE: begin
          if (mode == M_CH_HEX && !hv[4] && esc < 2'd2) begin
            acc_next = {acc[27:0], hv[3:0]}; tlen_next = tlen_inc;
            esc_next = esc + 1'b1;
            if (esc == 2'd1) mode_next = M_CH_CLOSE;
          end else if (c == "'") begin
            emit_now = 1'b1; emit_kind = cst_pkg::K_CHAR; emit_val = acc;
            tlen_next = tlen_inc; mode_next = M_IDLE;
          end else begin
            emit_now = 1'b1; emit_kind = cst_pkg::K_CHAR; emit_val = acc; restart = 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase
    end

    // first token uses the length as updated this beat where the byte belongs to it
    if (emit_now) begin
      t0 = mk(emit_kind, emit_val, (restart || flush) ? tlen : tlen_next, tline, tcol);
      n = 2'd1;
      if (!restart) mode_next = M_IDLE;
    end

    // start a new token from idle
    if (restart) begin
      mode_next = M_IDLE;
      if (!(c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a)) begin
        tline_next = cline; tcol_next = ccol; tlen_next = LengthBits'(1);
        acc_next = '0; esc_next = '0;
        if (is_alpha(c)) begin
          mode_next = M_IDENT; cand_next = narrow('1, '0, c);
        end else if (c == "0") mode_next = M_ZERO;
        else if (is_num(c)) begin mode_next = M_DEC; acc_next = 32'(c - "0"); end
        else if (c == "\"") mode_next = M_STR;
        else if (c == "'") mode_next = M_CH_OPEN;
        else if (cst_pkg::starts_pair(c)) begin mode_next = M_OP; held_next = c; end
        else begin
          if (emit_now) begin
            t1 = mk(cst_pkg::single_kind(c), '0, LengthBits'(1), cline, ccol); n = 2'd2;
          end else begin
            t0 = mk(cst_pkg::single_kind(c), '0, LengthBits'(1), cline, ccol); n = 2'd1;
          end
        end
      end
    end

    // end marker after a flush
    if (flush) begin
      if (emit_now) begin
        t1 = mk(cst_pkg::K_END, '0, '0, cline, ccol); n = 2'd2;
      end else begin
        t0 = mk(cst_pkg::K_END, '0, '0, cline, ccol); n = 2'd1;
      end
    end
    if (n == 2'd1) t0.last = 1'b1;
    if (n == 2'd2) t1.last = 1'b1;
  end

  assign n_tok = take ? n : 2'd0;
  assign tok0  = t0;
  assign tok1  = t1;

  // state registers
  always_ff @(posedge clk) begin
    if (rst || (take && flush)) begin
      mode <= M_IDLE; held <= '0; acc <= '0; cand <= '1; tlen <= '0;
      tline <= LineBits'(1); tcol <= ColumnBits'(1);
      cline <= LineBits'(1); ccol <= ColumnBits'(1); esc <= '0;
    end else if (take) begin
      mode <= mode_next; held <= held_next; acc <= acc_next; cand <= cand_next;
      tlen <= tlen_next; tline <= tline_next; tcol <= tcol_next; esc <= esc_next;
      if (c == 8'h0a) begin
        if (cline != LineMax) cline <= cline + 1'b1;
        ccol <= ColumnBits'(1);
      end else if (ccol != ColMax) begin
        ccol <= ccol + 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/cst_queue.sv
// back part: token queue, two writes and one read a cycle
module cst_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      n_in,
  input  cst_pkg::token_t tok0,
  input  cst_pkg::token_t tok1,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output cst_pkg::token_t out_tok
);

  localparam int Depth = 4;

  cst_pkg::token_t mem [Depth];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = cnt != 3'd0;
  assign out_tok   = mem[rp];
  // two free slots needed so a beat never stalls mid-way
  assign room      = cnt <= 3'd2;

  // queue storage
  always_ff @(posedge clk) begin
    if (n_in != 2'd0) mem[wp] <= tok0;
    if (n_in == 2'd2) mem[wp + 2'd1] <= tok1;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      wp  <= wp + n_in;
      rp  <= rp + 2'(pop);
      cnt <= cnt + 3'(n_in) - 3'(pop);
    end
  end

endmodule

// File: hw/rtl/c_subset_tokenizer.sv
// output: a completed token is registered in the token queue before it leaves
// throughput: one byte a cycle; up to two tokens per byte drain at one a cycle,
// while m_tready is high, via a four-entry token queue that stalls input above two
// reset: rst is synchronous, returns to between-tokens at line 1 column 1
// a zero byte or end_of_source also flushes and resets the scanner
module c_subset_tokenizer #(
  parameter int LengthBits = cst_pkg::LengthBitsDefault,
  parameter int LineBits   = cst_pkg::LineBitsDefault,
  parameter int ColumnBits = cst_pkg::ColumnBitsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // ch
  input  logic         s_tlast,   // end_of_source
  output logic         m_tvalid,
  input  logic         m_tready,
  // kind[6:0], value[38:7], length, line, column, zero fill to whole bytes
  output logic [((7 + 32 + LengthBits + LineBits + ColumnBits + 7) / 8) * 8 - 1:0] m_tdata,
  output logic         m_tlast    // last
);

  localparam int Used = 7 + 32 + LengthBits + LineBits + ColumnBits;
  localparam int TW   = ((Used + 7) / 8) * 8;

  logic [1:0]      n_tok;
  cst_pkg::token_t tok0, tok1, qt;
  logic            room;

  assign s_tready = room;

  cst_scan #(.LengthBits(LengthBits), .LineBits(LineBits), .ColumnBits(ColumnBits)) u_scan (
    .clk, .rst, .take(s_tvalid && room), .ch(s_tdata), .eos(s_tlast),
    .n_tok, .tok0, .tok1
  );

  cst_queue u_queue (
    .clk, .rst, .n_in(n_tok), .tok0, .tok1, .room,
    .out_valid(m_tvalid), .out_ready(m_tready), .out_tok(qt)
  );

  // pack the output beat
  assign m_tdata = TW'({qt.column[ColumnBits-1:0], qt.line[LineBits-1:0],
                        qt.length[LengthBits-1:0], qt.value, qt.kind});
  assign m_tlast = qt.last;

endmodule
